[hdl/ifd_pkg.sv]
// Shared constants and types for the IMU fall detector.
package ifd_pkg;

  // Default sizing of the sample windows
  localparam int WindowDefault      = 8;
  localparam int SampleWidthDefault = 16;

  // Fixed field widths
  localparam int CycleWidth     = 32;
  localparam int ThresholdWidth = 15;
  localparam int CfgIdxWidth    = 1;
  localparam int CfgDataWidth   = ThresholdWidth;
  localparam int OutTdataWidth  = 8;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegForceThreshold = 1'd0;
  localparam logic [CfgIdxWidth-1:0] RegForceStop      = 1'd1;

  // Reset values of the configuration registers
  localparam logic [ThresholdWidth-1:0] ThresholdReset = 15'd160;

  // Fall direction codes
  localparam logic [1:0] DirBack  = 2'd0;
  localparam logic [1:0] DirFront = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  // Configuration register set
  typedef struct packed {
    logic [ThresholdWidth-1:0] force_threshold;
    logic                      force_stop;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic       sample_taken;
    logic [1:0] fall_direction;
    logic       fallen;
  } result_t;

endpackage

[hdl/ifd_window.sv]
// Sliding window of samples as a shift line with a running total.
module ifd_window #(
  parameter int WINDOW  = ifd_pkg::WindowDefault,
  parameter int WIDTH   = ifd_pkg::SampleWidthDefault,
  parameter int TOTAL_W = WIDTH + $clog2(WINDOW)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic signed [WIDTH-1:0]   sample_i,
  output logic signed [TOTAL_W-1:0] total_o
);

  logic signed [WIDTH-1:0]   taps_q [WINDOW];
  logic signed [TOTAL_W-1:0] total_q;
  logic signed [TOTAL_W-1:0] total_d;

  // Add the new sample and drop the oldest one
  assign total_d = total_q + TOTAL_W'(sample_i) - TOTAL_W'(taps_q[WINDOW-1]);

  // Advance the shift line on each stored sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        taps_q[i] <= '0;
      end
      total_q <= '0;
    end else if (shift_i) begin
      taps_q[0] <= sample_i;
      for (int i = 1; i < WINDOW; i++) begin
        taps_q[i] <= taps_q[i-1];
      end
      total_q <= total_d;
    end
  end

  assign total_o = total_q;

endmodule

[hdl/ifd_decide.sv]
// Fall and direction decision from the window totals.
module ifd_decide #(
  parameter int WINDOW  = ifd_pkg::WindowDefault,
  parameter int GYRO_W  = ifd_pkg::SampleWidthDefault + $clog2(WINDOW),
  parameter int FORCE_W = ifd_pkg::SampleWidthDefault + 1 + $clog2(WINDOW)
) (
  input  logic signed [GYRO_W-1:0]  gyro_x_total_i,
  input  logic signed [GYRO_W-1:0]  gyro_y_total_i,
  input  logic signed [FORCE_W-1:0] force_total_i,
  input  ifd_pkg::cfg_t             cfg_i,
  output logic                      fallen_o,
  output logic [1:0]                fall_direction_o
);

  localparam int ThrW = ifd_pkg::ThresholdWidth + $clog2(WINDOW + 1);
  localparam int CmpW = ((ThrW > FORCE_W) ? ThrW : FORCE_W) + 1;

  logic signed [CmpW-1:0]   thr_scaled;
  logic signed [CmpW-1:0]   force_ext;
  logic        [GYRO_W-1:0] abs_x;
  logic        [GYRO_W-1:0] abs_y;
  logic                     x_pos;
  logic                     x_neg;

  // Compare the force total against threshold times window length
  assign thr_scaled = $signed(CmpW'(cfg_i.force_threshold) * CmpW'(WINDOW));
  assign force_ext  = CmpW'(force_total_i);
  assign fallen_o   = !cfg_i.force_stop && (force_ext <= thr_scaled);

  // Magnitudes of the gyro totals
  assign abs_x = gyro_x_total_i[GYRO_W-1] ? GYRO_W'(-gyro_x_total_i) : gyro_x_total_i;
  assign abs_y = gyro_y_total_i[GYRO_W-1] ? GYRO_W'(-gyro_y_total_i) : gyro_y_total_i;
  assign x_neg = gyro_x_total_i[GYRO_W-1];
  assign x_pos = !x_neg && (gyro_x_total_i != '0);

  // Pick direction; ties fall through to right
  always_comb begin
    if (abs_x > abs_y && x_pos) begin
      fall_direction_o = ifd_pkg::DirBack;
    end else if (abs_x > abs_y && x_neg) begin
      fall_direction_o = ifd_pkg::DirFront;
    end else if (abs_x < abs_y && x_pos) begin
      fall_direction_o = ifd_pkg::DirLeft;
    end else begin
      fall_direction_o = ifd_pkg::DirRight;
    end
  end

endmodule

[hdl/imu_fall_detector.sv]
// Top level of the IMU fall detector: input register, windows, result register.
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+--------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | cycle, gyro x/y, force right/left
//  m_axis   | out | m_axis_tvalid/m_axis_tready | fallen, fall_direction, sample_taken
//  cfg      | in  | cfg_we_i                    | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while m_axis does not stall; after acceptance the input
// register takes the item, the update stage updates the windows, then the result register loads.
// Reset clears the windows, totals and cycle tracking and resets the config at once; no clearing pass.
// A stall on m_axis holds the result register, then the update stage, then s_axis.
module imu_fall_detector #(
  parameter int WINDOW       = ifd_pkg::WindowDefault,
  parameter int SAMPLE_WIDTH = ifd_pkg::SampleWidthDefault,
  parameter int IN_TDATA_W   = ((ifd_pkg::CycleWidth + 4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input item
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // from bit 0: cycle_number, gyro_x, gyro_y, force_right, force_left, zero pad
  input  logic [IN_TDATA_W-1:0]             s_axis_tdata,
  // Result item
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // from bit 0: fallen, fall_direction[1:0], sample_taken, zero pad
  output logic [ifd_pkg::OutTdataWidth-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic [ifd_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [ifd_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  localparam int CW      = ifd_pkg::CycleWidth;
  localparam int SW      = SAMPLE_WIDTH;
  localparam int FSW     = SAMPLE_WIDTH + 1;
  localparam int GYRO_W  = SW + $clog2(WINDOW);
  localparam int FORCE_W = FSW + $clog2(WINDOW);

  // Configuration registers
  ifd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_threshold <= ifd_pkg::ThresholdReset;
      cfg_q.force_stop      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ifd_pkg::RegForceThreshold: cfg_q.force_threshold <= cfg_data_i;
        ifd_pkg::RegForceStop:      cfg_q.force_stop      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic in_valid_q;
  logic mid_valid_q;
  logic out_valid_q;
  logic upd_ready;
  logic upd_fire;
  logic out_adv;

  assign out_adv       = mid_valid_q && (!out_valid_q || m_axis_tready);
  assign upd_ready     = !mid_valid_q || out_adv;
  assign upd_fire      = in_valid_q && upd_ready;
  assign s_axis_tready = !in_valid_q || upd_ready;

  // Input register
  logic [CW-1:0]        cycle_q;
  logic signed [SW-1:0] gyro_x_q;
  logic signed [SW-1:0] gyro_y_q;
  logic signed [SW-1:0] force_right_q;
  logic signed [SW-1:0] force_left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cycle_q       <= s_axis_tdata[CW-1:0];
      gyro_x_q      <= s_axis_tdata[CW+SW-1:CW];
      gyro_y_q      <= s_axis_tdata[CW+2*SW-1:CW+SW];
      force_right_q <= s_axis_tdata[CW+3*SW-1:CW+2*SW];
      force_left_q  <= s_axis_tdata[CW+4*SW-1:CW+3*SW];
    end
  end

  // Cycle tracking: store a sample only on a new cycle number
  logic [CW-1:0] last_cycle_q;
  logic          cycle_known_q;
  logic          take;
  logic          shift;
  logic          taken_q;

  assign take  = !cycle_known_q || (cycle_q != last_cycle_q);
  assign shift = upd_fire && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cycle_q  <= '0;
      cycle_known_q <= 1'b0;
      mid_valid_q   <= 1'b0;
      taken_q       <= 1'b0;
    end else begin
      if (upd_fire) begin
        last_cycle_q  <= cycle_q;
        cycle_known_q <= 1'b1;
        taken_q       <= take;
        mid_valid_q   <= 1'b1;
      end else if (out_adv) begin
        mid_valid_q   <= 1'b0;
      end
    end
  end

  // Summed foot force
  logic signed [FSW-1:0] force_sum;
  assign force_sum = FSW'(force_right_q) + FSW'(force_left_q);

  // Windows and running totals
  logic signed [GYRO_W-1:0]  gyro_x_total;
  logic signed [GYRO_W-1:0]  gyro_y_total;
  logic signed [FORCE_W-1:0] force_total;

  ifd_window #(.WINDOW(WINDOW), .WIDTH(SW), .TOTAL_W(GYRO_W)) u_win_gx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (shift),
    .sample_i (gyro_x_q),
    .total_o  (gyro_x_total)
  );

  ifd_window #(.WINDOW(WINDOW), .WIDTH(SW), .TOTAL_W(GYRO_W)) u_win_gy (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (shift),
    .sample_i (gyro_y_q),
    .total_o  (gyro_y_total)
  );

  ifd_window #(.WINDOW(WINDOW), .WIDTH(FSW), .TOTAL_W(FORCE_W)) u_win_force (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (shift),
    .sample_i (force_sum),
    .total_o  (force_total)
  );

  // Decision from the updated totals
  logic       fallen;
  logic [1:0] fall_direction;

  ifd_decide #(.WINDOW(WINDOW), .GYRO_W(GYRO_W), .FORCE_W(FORCE_W)) u_decide (
    .gyro_x_total_i   (gyro_x_total),
    .gyro_y_total_i   (gyro_y_total),
    .force_total_i    (force_total),
    .cfg_i            (cfg_q),
    .fallen_o         (fallen),
    .fall_direction_o (fall_direction)
  );

  // Result register
  ifd_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      res_q.fallen         <= fallen;
      res_q.fall_direction <= fall_direction;
      res_q.sample_taken   <= taken_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ifd_pkg::OutTdataWidth'(res_q);

endmodule
